### sv/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, sizes and character codes for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // Depth of the bracket stack, in entries.
   localparam int STACK_DEPTH = 64;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int RSP_W       = 8;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(STACK_DEPTH);

   localparam logic [CHAR_W-1:0] CHAR_OPEN_ROUND   = 8'h28;  // (
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_ROUND  = 8'h29;  // )
   localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;  // [
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;  // ]
   localparam logic [CHAR_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;  // {
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;  // }

   typedef enum logic [KIND_W-1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MISMATCH = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_UNCLOSED = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   function automatic kind_type opener_kind(input logic [CHAR_W-1:0] c);
      kind_type k;
      case (c)
         CHAR_OPEN_ROUND:  k = KIND_ROUND;
         CHAR_OPEN_SQUARE: k = KIND_SQUARE;
         CHAR_OPEN_CURLY:  k = KIND_CURLY;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [CHAR_W-1:0] c);
      kind_type k;
      case (c)
         CHAR_CLOSE_ROUND:  k = KIND_ROUND;
         CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
         CHAR_CLOSE_CURLY:  k = KIND_CURLY;
         default:           k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

### sv/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### sv/bracket_balance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks a byte stream for balanced round, square and curly brackets.
// ----------------------------------------------------------------------------
// The result of an expression is registered and is valid in the cycle after
// its last character transaction is accepted.
// Throughput: one character per cycle while no untaken result holds the input,
// set by the stack RAM's single read port and its registered read, which the
// top-of-stack register and the prefetched entry below it hide.
// Reset clears the stack level, the error code and the result valid flag; the
// stack RAM itself is not cleared and needs no clearing pass.
module bracket_balance_checker (
   input  logic                       clock,
   input  logic                       reset,
   // Character stream.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bbc_pkg::CHAR_W-1:0] req_tdata,  // [7:0] char_code
   input  logic                       req_tlast,  // last_char
   // Result stream.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bbc_pkg::RSP_W-1:0]  rsp_tdata   // [0] balanced, [3:1] status, rest zero
);

   import bbc_pkg::*;

   // The stack lives in a RAM. The entry on top is also kept in top_ff, so a
   // closing bracket can be compared at once. Every cycle the RAM is read at
   // the address of the entry just below the next top, so after a pop the
   // new top is already on the read port. A push writes at the current level,
   // which is never the address being prefetched, so no forwarding is needed.
   logic [LEVEL_W-1:0] level_ff, level_in;
   kind_type           top_ff, top_in;
   status_type         err_ff, err_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               req_accept;
   kind_type           open_kind;
   kind_type           close_kind;
   status_type         final_status;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [KIND_W-1:0]  ram_rd_data;
   logic [LEVEL_W-1:0] prefetch_level;
   logic [ADDR_W-1:0]  ram_rd_addr;

   // The input waits only while a result is held and not being taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign open_kind  = opener_kind(req_tdata);
   assign close_kind = closer_kind(req_tdata);

   always_comb begin
      level_in     = level_ff;
      top_in       = top_ff;
      err_in       = err_ff;
      ram_wr_en    = 1'b0;
      final_status = ST_OK;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (req_accept) begin
         // Once an error is recorded, the rest of the expression is ignored.
         if (err_ff == ST_OK) begin
            if (open_kind != KIND_NONE) begin
               if (level_ff == FULL_LEVEL) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  ram_wr_en = 1'b1;
                  top_in    = open_kind;
                  level_in  = LEVEL_W'(level_ff + 1'b1);
               end
            end else if (close_kind != KIND_NONE) begin
               if (level_ff == '0) begin
                  err_in = ST_EMPTY;
               end else if (top_ff == close_kind) begin
                  level_in = LEVEL_W'(level_ff - 1'b1);
                  top_in   = kind_type'(ram_rd_data);
               end else begin
                  err_in = ST_MISMATCH;
               end
            end
         end

         // The last character closes the expression and starts a new one.
         if (req_tlast) begin
            if (err_in == ST_OK && level_in != '0) begin
               final_status = ST_UNCLOSED;
            end else begin
               final_status = err_in;
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = {(RSP_W - 4)'(0), final_status, (final_status == ST_OK)};
            level_in     = '0;
            err_in       = ST_OK;
         end
      end
   end

   assign ram_wr_addr    = level_ff[ADDR_W-1:0];
   assign prefetch_level = LEVEL_W'(level_in - LEVEL_W'(2));
   assign ram_rd_addr    = prefetch_level[ADDR_W-1:0];

   bbc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (open_kind),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff      <= top_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The stack never holds more entries than the RAM has.
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      level_ff <= FULL_LEVEL)
      else $error("stack level beyond stack depth");

   // After the last character of an expression the checker starts afresh.
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (level_ff == '0 && err_ff == ST_OK))
      else $error("state not cleared after last character");

   // A new result only appears after a last character was accepted.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && req_tlast))
      else $error("result without a last character");

   // The balanced flag agrees with the status code.
   a_flag_matches_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[0] == (rsp_data_ff[3:1] == ST_OK)))
      else $error("balanced flag disagrees with status");

   // An error is only recorded while the expression was still error-free.
   a_sticky_error : assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !(req_accept && req_tlast)) |=> $stable(err_ff))
      else $error("recorded error changed before end of expression");

endmodule
